// ===== rtl/core/rar_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the fraction unit.
package rar_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int ACTION_W      = 2;
   localparam int MAG_W         = OPERAND_WIDTH;
   localparam int NUM_W         = 2 * OPERAND_WIDTH;
   localparam int CNT_W         = $clog2(NUM_W);
   localparam int RES_NUM_W     = 33;
   localparam int RES_DEN_W     = 31;

   localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SUB = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MUL = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_DIV = 2'd3;

   localparam logic [1:0] MSEL_DEN = 2'd0;
   localparam logic [1:0] MSEL_T1  = 2'd1;
   localparam logic [1:0] MSEL_T2  = 2'd2;

   localparam logic [1:0] EMIT_OK   = 2'd0;
   localparam logic [1:0] EMIT_ZERO = 2'd1;
   localparam logic [1:0] EMIT_ERR  = 2'd2;

   localparam logic ST_OK  = 1'b0;
   localparam logic ST_ERR = 1'b1;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       form;
      logic       gcd_step;
      logic       div_step;
      logic       emit;
      logic [1:0] emit_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic num_zero;
      logic gcd_done;
   } dp_status_type;

endpackage

// ===== rtl/core/rational_arith_reduce.sv =====
// Top level: fraction add/subtract/multiply/divide with reduction to lowest terms.
// Usage:
//   Drive req_action and the four operand fields and raise start while busy is
//   low; the request is taken at that clock edge and busy rises the next cycle.
//   The result appears on rsp_res_num, rsp_res_den and rsp_status for exactly
//   one cycle, marked by rsp_valid. The receiver cannot stall; the result is
//   taken at the edge that ends the strobe cycle. busy is already low during
//   the strobe, so the next request may be issued in that cycle.
// Sequence: the denominator and two numerator products on one shared multiplier,
//   a sum step, a binary GCD of the sum and denominator (one step per cycle,
//   its step count set by the operand bit counts), NUM_W restoring divide steps for
//   numerator and denominator in parallel, then an emit step. Errors (zero
//   denominator, division by a zero fraction) go from the first multiply state
//   straight to emit, and zero results go to emit from the GCD state.
// Throughput: one request at a time; the next is taken in the strobe cycle at the earliest.
// Reset: synchronous and active high; returns the controller to idle and drops
//   the strobe. A request in flight is lost.
module rational_arith_reduce import rar_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ACTION_W-1:0]         req_action,
   input  logic signed [MAG_W-1:0]     req_a_num,
   input  logic signed [MAG_W-1:0]     req_a_den,
   input  logic signed [MAG_W-1:0]     req_b_num,
   input  logic signed [MAG_W-1:0]     req_b_den,
   output logic                        rsp_valid,
   output logic signed [RES_NUM_W-1:0] rsp_res_num,
   output logic [RES_DEN_W-1:0]        rsp_res_den,
   output logic                        rsp_status
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ctrl_busy;

   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (ctrl_busy),
      .rsp_valid (rsp_valid)
   );

   rar_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_action),
      .req_a_num  (req_a_num),
      .req_a_den  (req_a_den),
      .req_b_num  (req_b_num),
      .req_b_den  (req_b_den),
      .status     (status),
      .res_num    (rsp_res_num),
      .res_den    (rsp_res_den),
      .res_status (rsp_status)
   );

   assign busy = ctrl_busy;

endmodule

// ===== rtl/core/rar_datapath.sv =====
// Datapath: operand registers, shared multiplier, binary GCD and dual restoring divider.
module rar_datapath import rar_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   input  logic [ACTION_W-1:0]         req_action,
   input  logic signed [MAG_W-1:0]     req_a_num,
   input  logic signed [MAG_W-1:0]     req_a_den,
   input  logic signed [MAG_W-1:0]     req_b_num,
   input  logic signed [MAG_W-1:0]     req_b_den,
   output dp_status_type               status,
   output logic signed [RES_NUM_W-1:0] res_num,
   output logic [RES_DEN_W-1:0]        res_den,
   output logic                        res_status
);

   function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] x);
      return x[MAG_W-1] ? (~x + 1'b1) : x;
   endfunction

   logic               err_ff, prod_form_ff;
   logic [MAG_W-1:0]   an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic               an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic [NUM_W-1:0]   den_mag_ff, t1_mag_ff, t2_mag_ff;
   logic               den_neg_ff, t1_neg_ff, t2_neg_ff, num_neg_ff;
   logic [NUM_W-1:0]   u_ff, v_ff, sn_ff, sd_ff, rn_ff, rd_ff;
   logic signed [RES_NUM_W-1:0] res_num_ff;
   logic [RES_DEN_W-1:0] res_den_ff;
   logic               res_status_ff;

   logic               is_div, is_sub;
   logic [MAG_W-1:0]   bn_raw, bd_raw;
   logic [MAG_W-1:0]   mul_a, mul_b;
   logic               mul_neg;
   logic [NUM_W-1:0]   mul_p;
   logic [NUM_W-1:0]   sum_mag;
   logic               sum_neg;
   logic [NUM_W:0]     uv_diff, vu_diff;
   logic [NUM_W:0]     trial_n, trial_d;
   logic               fit_n, fit_d;

   assign is_div = (req_action == ACT_DIV);
   assign is_sub = (req_action == ACT_SUB);
   // division takes the reciprocal of the second fraction
   assign bn_raw = is_div ? req_b_den : req_b_num;
   assign bd_raw = is_div ? req_b_num : req_b_den;

   always_comb begin
      mul_a   = an_mag_ff;
      mul_b   = bd_mag_ff;
      mul_neg = an_neg_ff ^ bd_neg_ff;
      case (cmd.mul_sel)
         MSEL_DEN: begin
            mul_a   = ad_mag_ff;
            mul_b   = bd_mag_ff;
            mul_neg = ad_neg_ff ^ bd_neg_ff;
         end
         MSEL_T1: begin
            mul_a   = an_mag_ff;
            mul_b   = prod_form_ff ? bn_mag_ff : bd_mag_ff;
            mul_neg = an_neg_ff ^ (prod_form_ff ? bn_neg_ff : bd_neg_ff);
         end
         MSEL_T2: begin
            mul_a   = ad_mag_ff;
            mul_b   = bn_mag_ff;
            mul_neg = ad_neg_ff ^ bn_neg_ff;
         end
         default: begin
            mul_a   = an_mag_ff;
            mul_b   = bd_mag_ff;
            mul_neg = an_neg_ff ^ bd_neg_ff;
         end
      endcase
   end

   assign mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);

   // sign-magnitude sum of the two cross products, or the product alone for multiply and divide
   always_comb begin
      if (prod_form_ff) begin
         sum_mag = t1_mag_ff;
         sum_neg = t1_neg_ff;
      end else if (t1_neg_ff == t2_neg_ff) begin
         sum_mag = t1_mag_ff + t2_mag_ff;
         sum_neg = t1_neg_ff;
      end else if (t1_mag_ff >= t2_mag_ff) begin
         sum_mag = t1_mag_ff - t2_mag_ff;
         sum_neg = t1_neg_ff;
      end else begin
         sum_mag = t2_mag_ff - t1_mag_ff;
         sum_neg = t2_neg_ff;
      end
   end

   assign uv_diff = {1'b0, u_ff} - {1'b0, v_ff};
   assign vu_diff = {1'b0, v_ff} - {1'b0, u_ff};

   assign trial_n = {rn_ff, sn_ff[NUM_W-1]};
   assign trial_d = {rd_ff, sd_ff[NUM_W-1]};
   assign fit_n   = (trial_n >= {1'b0, u_ff});
   assign fit_d   = (trial_d >= {1'b0, u_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         an_mag_ff    <= mag_of(req_a_num);
         an_neg_ff    <= req_a_num[MAG_W-1];
         ad_mag_ff    <= mag_of(req_a_den);
         ad_neg_ff    <= req_a_den[MAG_W-1];
         bn_mag_ff    <= mag_of(bn_raw);
         bn_neg_ff    <= bn_raw[MAG_W-1] ^ is_sub;
         bd_mag_ff    <= mag_of(bd_raw);
         bd_neg_ff    <= bd_raw[MAG_W-1];
         prod_form_ff <= (req_action == ACT_MUL) || is_div;
         err_ff       <= (req_a_den == '0) || (req_b_den == '0) ||
                         (is_div && (req_b_num == '0));
      end

      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_DEN: begin
               den_mag_ff <= mul_p;
               den_neg_ff <= mul_neg;
            end
            MSEL_T1: begin
               t1_mag_ff <= mul_p;
               t1_neg_ff <= mul_neg;
            end
            MSEL_T2: begin
               t2_mag_ff <= mul_p;
               t2_neg_ff <= mul_neg;
            end
            default: begin
               t1_mag_ff <= t1_mag_ff;
            end
         endcase
      end

      if (cmd.form) begin
         num_neg_ff <= sum_neg ^ den_neg_ff;
         u_ff       <= sum_mag;
         v_ff       <= den_mag_ff;
         sn_ff      <= sum_mag;
         sd_ff      <= den_mag_ff;
         rn_ff      <= '0;
         rd_ff      <= '0;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            // common factor of two: strip it from the dividends too
            u_ff  <= u_ff >> 1;
            v_ff  <= v_ff >> 1;
            sn_ff <= sn_ff >> 1;
            sd_ff <= sd_ff >> 1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (!uv_diff[NUM_W]) begin
            u_ff <= {1'b0, uv_diff[NUM_W-1:1]};
         end else begin
            v_ff <= {1'b0, vu_diff[NUM_W-1:1]};
         end
      end else if (cmd.div_step) begin
         // sn/sd shift out dividend bits and shift in quotient bits
         rn_ff <= fit_n ? NUM_W'(trial_n - {1'b0, u_ff}) : trial_n[NUM_W-1:0];
         rd_ff <= fit_d ? NUM_W'(trial_d - {1'b0, u_ff}) : trial_d[NUM_W-1:0];
         sn_ff <= {sn_ff[NUM_W-2:0], fit_n};
         sd_ff <= {sd_ff[NUM_W-2:0], fit_d};
      end

      if (cmd.emit) begin
         case (cmd.emit_kind)
            EMIT_OK: begin
               res_num_ff    <= num_neg_ff ? -RES_NUM_W'(sn_ff) : RES_NUM_W'(sn_ff);
               res_den_ff    <= RES_DEN_W'(sd_ff);
               res_status_ff <= ST_OK;
            end
            EMIT_ZERO: begin
               res_num_ff    <= '0;
               res_den_ff    <= RES_DEN_W'(1);
               res_status_ff <= ST_OK;
            end
            default: begin
               res_num_ff    <= '0;
               res_den_ff    <= RES_DEN_W'(1);
               res_status_ff <= ST_ERR;
            end
         endcase
      end
   end

   assign status.err      = err_ff;
   assign status.num_zero = (sn_ff == '0);
   assign status.gcd_done = (u_ff == v_ff);

   assign res_num    = res_num_ff;
   assign res_den    = res_den_ff;
   assign res_status = res_status_ff;

   a_gcd_operands_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> (u_ff != '0) && (v_ff != '0))
      else $error("gcd step on a zero operand");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (u_ff != '0))
      else $error("division by a zero divisor");

endmodule

// ===== rtl/core/rar_ctrl.sv =====
// Controller: sequences load, multiply, sum, GCD and divide steps and issues the result strobe.
module rar_ctrl import rar_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL0 = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_FORM = 3'd4;
   localparam logic [2:0] S_GCD  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       kind_ff, kind_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.emit_kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_DEN;
            if (status.err) begin
               kind_in  = EMIT_ERR;
               state_in = S_EMIT;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_T1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_T2;
            state_in    = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (status.num_zero) begin
               kind_in  = EMIT_ZERO;
               state_in = S_EMIT;
            end else if (status.gcd_done) begin
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               kind_in  = EMIT_OK;
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_EMIT: begin
            cmd.emit     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff  <= cnt_in;
      kind_ff <= kind_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while busy");

   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_EMIT))
      else $error("result strobe without emit");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (start && (state_ff == S_IDLE)) |=> (state_ff == S_MUL0))
      else $error("request accepted but not started");

endmodule

// ===== test/tb_rational_arith_reduce.sv =====
// Self-checking testbench for rational_arith_reduce: directed table plus random fraction requests.
module tb_rational_arith_reduce;
   import rar_pkg::*;

   localparam int N_DIRECTED = 24;
   localparam int N_RANDOM   = 1230;
   localparam int N_STEADY   = 150;
   localparam int TAIL_WAIT  = 150;

   typedef struct packed {
      logic signed [RES_NUM_W-1:0] num;
      logic [RES_DEN_W-1:0]        den;
      logic                        status;
   } fraction_type;

   typedef struct packed {
      logic [ACTION_W-1:0]     act;
      logic signed [MAG_W-1:0] an;
      logic signed [MAG_W-1:0] ad;
      logic signed [MAG_W-1:0] bn;
      logic signed [MAG_W-1:0] bd;
      logic                    known;
      fraction_type            want;
   } row_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [ACTION_W-1:0]         req_action;
   logic signed [MAG_W-1:0]     req_a_num;
   logic signed [MAG_W-1:0]     req_a_den;
   logic signed [MAG_W-1:0]     req_b_num;
   logic signed [MAG_W-1:0]     req_b_den;
   logic                        rsp_valid;
   logic signed [RES_NUM_W-1:0] rsp_res_num;
   logic [RES_DEN_W-1:0]        rsp_res_den;
   logic                        rsp_status;

   fraction_type pending_results[$];
   int           mismatches = 0;

   // Error rows, zero results, some extremes and small cases carry their result; the rest use the predictor.
   row_type directed_rows [N_DIRECTED] = '{
      '{ACT_ADD,      1,      0,      1,      1, 1'b1, '{0, 1, ST_ERR}},
      '{ACT_MUL,      1,      1,      1,      0, 1'b1, '{0, 1, ST_ERR}},
      '{ACT_DIV,      3,      4,      0,      5, 1'b1, '{0, 1, ST_ERR}},
      '{ACT_DIV,      1,      1,      0,      0, 1'b1, '{0, 1, ST_ERR}},
      '{ACT_SUB, -32768,      0, -32768,      0, 1'b1, '{0, 1, ST_ERR}},
      '{ACT_ADD,      0,      5,      0,      7, 1'b1, '{0, 1, ST_OK}},
      '{ACT_SUB,      5,      3,      5,      3, 1'b1, '{0, 1, ST_OK}},
      '{ACT_DIV,      0,      7,      3,      5, 1'b1, '{0, 1, ST_OK}},
      '{ACT_MUL, -32768,      1, -32768,      1, 1'b1, '{1073741824, 1, ST_OK}},
      '{ACT_MUL,      1, -32768,      1, -32768, 1'b1, '{1, 1073741824, ST_OK}},
      '{ACT_ADD, -32768,      1, -32768,      1, 1'b1, '{-65536, 1, ST_OK}},
      '{ACT_SUB,  32767,      1, -32768,      1, 1'b1, '{65535, 1, ST_OK}},
      '{ACT_DIV, -32768,      1,      1, -32768, 1'b1, '{1073741824, 1, ST_OK}},
      '{ACT_MUL, -32768, -32768, -32768, -32768, 1'b1, '{1, 1, ST_OK}},
      '{ACT_DIV, -32768, -32768, -32768, -32768, 1'b1, '{1, 1, ST_OK}},
      '{ACT_ADD,      1,      2,      1,      3, 1'b1, '{5, 6, ST_OK}},
      '{ACT_SUB,      1,      2,      1,      3, 1'b1, '{1, 6, ST_OK}},
      '{ACT_MUL,      2,      3,      3,      4, 1'b1, '{1, 2, ST_OK}},
      '{ACT_DIV,      2,      3,      4,      9, 1'b1, '{3, 2, ST_OK}},
      '{ACT_ADD,      3,     -4,      1,      4, 1'b0, '{0, 1, ST_OK}},
      '{ACT_DIV,      7,     -9,    -14,     27, 1'b0, '{0, 1, ST_OK}},
      '{ACT_SUB,  32767, -32768, -32768,  32767, 1'b0, '{0, 1, ST_OK}},
      '{ACT_ADD,      1,  32767,      1, -32768, 1'b0, '{0, 1, ST_OK}},
      '{ACT_MUL,  32767,  32767,  32767, -32767, 1'b0, '{0, 1, ST_OK}}
   };

   rational_arith_reduce dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_action  (req_action),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .rsp_valid   (rsp_valid),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_status  (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic fraction_type reduce_fraction(input logic [ACTION_W-1:0] act,
                                                    input logic signed [MAG_W-1:0] an_f,
                                                    input logic signed [MAG_W-1:0] ad_f,
                                                    input logic signed [MAG_W-1:0] bn_f,
                                                    input logic signed [MAG_W-1:0] bd_f);
      longint          an, ad, bn, bd, num, den, swap;
      longint unsigned x, y, t;
      fraction_type    r;
      an = an_f;
      ad = ad_f;
      bn = bn_f;
      bd = bd_f;
      if (ad == 0 || bd == 0 || (act == ACT_DIV && bn == 0)) begin
         r.num    = '0;
         r.den    = RES_DEN_W'(1);
         r.status = ST_ERR;
         return r;
      end
      if (act == ACT_SUB) bn = -bn;
      // divide by multiplying with the reciprocal
      if (act == ACT_DIV) begin
         swap = bn;
         bn   = bd;
         bd   = swap;
      end
      if (act == ACT_ADD || act == ACT_SUB) num = an * bd + ad * bn;
      else num = an * bn;
      den = ad * bd;
      // move the sign onto the numerator
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      x = (num < 0) ? -num : num;
      y = den;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      num = num / $signed(x);
      den = den / $signed(x);
      r.num    = num[RES_NUM_W-1:0];
      r.den    = den[RES_DEN_W-1:0];
      r.status = ST_OK;
      return r;
   endfunction

   function automatic logic signed [MAG_W-1:0] pick_operand();
      logic signed [MAG_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 16'sh8000;
               1: v = 16'sh7fff;
               2: v = -16'sd1;
               3: v = 16'sd1;
               default: v = '0;
            endcase
         end
         1, 2, 3: v = MAG_W'(int'($urandom_range(0, 40)) - 20);
         default: v = MAG_W'($urandom);
      endcase
      return v;
   endfunction

   // Present one request, hold it until taken, and record the expected result.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic signed [MAG_W-1:0] an,
                               input logic signed [MAG_W-1:0] ad,
                               input logic signed [MAG_W-1:0] bn,
                               input logic signed [MAG_W-1:0] bd,
                               input logic known,
                               input fraction_type want);
      start      <= 1'b1;
      req_action <= act;
      req_a_num  <= an;
      req_a_den  <= ad;
      req_b_num  <= bn;
      req_b_den  <= bd;
      do @(posedge clock); while (busy);
      if (known) pending_results.push_back(want);
      else pending_results.push_back(reduce_fraction(act, an, ad, bn, bd));
   endtask

   task automatic maybe_pause(input bit allow);
      if (allow && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [ACTION_W-1:0] act;
      row_type             r;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_action <= ACT_ADD;
      req_a_num  <= '0;
      req_a_den  <= '0;
      req_b_num  <= '0;
      req_b_den  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_request(r.act, r.an, r.ad, r.bn, r.bd, r.known, r.want);
         maybe_pause(1'b1);
      end
      // hold off until the unit has emptied out
      wait_drained();
      @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         act = ACTION_W'($urandom_range(0, 3));
         send_request(act, pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                      1'b0, '0);
         if (i < N_RANDOM - N_STEADY) begin
            if ($urandom_range(0, 99) == 0) begin
               wait_drained();
               @(posedge clock);
            end else begin
               maybe_pause(1'b1);
            end
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      // watch for stray results after the last one
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("** rational_arith_reduce: PASSED **");
      end else begin
         $display("** rational_arith_reduce: FAILED **");
      end
      $finish;
   end

   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request waiting: %0d/%0d status %0b",
                     $time, rsp_res_num, rsp_res_den, rsp_status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_num !== want.num) begin
               $display("%0t: res_num expected %0d, got %0d", $time, want.num, rsp_res_num);
               mismatches++;
            end
            if (rsp_res_den !== want.den) begin
               $display("%0t: res_den expected %0d, got %0d", $time, want.den, rsp_res_den);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0b, got %0b", $time, want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** rational_arith_reduce: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rar_pkg.sv
rtl/core/rar_datapath.sv
rtl/core/rar_ctrl.sv
rtl/core/rational_arith_reduce.sv
test/tb_rational_arith_reduce.sv
